// ===== hdl/serial_stream_framer_top_defines.svh =====
// ----------------------------------------------------------------------------
// serial stream framer assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SERIAL_STREAM_FRAMER_TOP_DEFINES_SVH
`define SERIAL_STREAM_FRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// types, register indexes and defaults shared by the serial stream framer
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int MAX_DELIM_DEF    = 4;
    localparam int CMD_Q_DEPTH      = 4;
    localparam int OUT_Q_DEPTH      = 4;
    localparam int DELIM_REG_BYTES  = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_FIXED = 2'd1,
        MODE_LINE  = 2'd2,
        MODE_IDLE  = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMING_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_BYTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BUFFER   = 3'd5;

    localparam logic [6:0]  FIXED_BYTES_RST  = 7'd16;
    localparam logic [31:0] DELIM_BYTES_RST  = 32'd10;
    localparam logic [2:0]  DELIM_LENGTH_RST = 3'd1;
    localparam logic [15:0] IDLE_GAP_RST     = 16'd50;
    localparam logic [6:0]  MAX_BUFFER_RST   = 7'd64;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        t_mode       framing_mode;
        logic [6:0]  fixed_frame_bytes;
        logic [31:0] delimiter_bytes;
        logic [2:0]  delimiter_length;
        logic [15:0] idle_gap_ticks;
        logic [6:0]  max_buffer_bytes;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_RAW   = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hdl/sfr_fifo.sv =====
// ----------------------------------------------------------------------------
// sfr_fifo
// small register queue used between the framer stages and at the output
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [NW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// accepts items, tracks idle ticks and turns each byte or closing tick into a buffer command
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  sfr_pkg::t_in_item i_item,
    input  sfr_pkg::t_cfg    i_cfg,
    output logic             o_cmd_push,
    output sfr_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_full
);

    import sfr_pkg::*;

    logic [15:0] r_idle_ticks;
    logic [15:0] n_idle_ticks;
    logic        accept;

    assign o_full = i_cmd_full;
    assign accept = i_push && !i_cmd_full;

    always_comb begin
        n_idle_ticks = r_idle_ticks;
        o_cmd_push   = 1'b0;
        o_cmd.kind   = CMD_BYTE;
        o_cmd.data   = i_item.rx_byte;
        if (accept) begin
            if (i_item.opcode == OP_BYTE) begin
                n_idle_ticks = '0;
                o_cmd_push   = 1'b1;
                o_cmd.kind   = (i_cfg.framing_mode == MODE_RAW) ? CMD_RAW : CMD_BYTE;
            end else begin
                if (r_idle_ticks != 16'hFFFF) begin
                    n_idle_ticks = r_idle_ticks + 16'd1;
                end
                // ticks that close nothing stop here
                if (i_cfg.framing_mode == MODE_IDLE && n_idle_ticks >= i_cfg.idle_gap_ticks)
                begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = CMD_FLUSH;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks <= '0;
        end else begin
            r_idle_ticks <= n_idle_ticks;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// frame buffer and sequencer: stores bytes, finds frame ends, drains frames
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back #(
    parameter int BUFFER_DEPTH        = 64,
    parameter int MAX_DELIMITER_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfr_pkg::t_cfg     i_cfg,
    input  logic              i_cfg_we,
    input  sfr_pkg::t_cmd     i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output logic              o_res_push,
    output sfr_pkg::t_out_item o_res,
    input  logic              i_res_full
);

    import sfr_pkg::*;

    localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW  = $clog2(BUFFER_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int EW  = (CW > 7) ? CW : 7;
    localparam int WFW = $clog2(MAX_DELIMITER_BYTES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIX,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    t_state         r_state, n_state;
    t_state         r_after, n_after;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_scan, n_scan;
    logic [CW-1:0]  r_rem, n_rem;
    logic [WFW-1:0] r_wfill, n_wfill;
    logic [7:0]     r_win [MAX_DELIMITER_BYTES];
    logic [7:0]     n_win [MAX_DELIMITER_BYTES];

    logic [7:0]     r_store [BUFFER_DEPTH];
    logic [7:0]     r_rdata;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic           mem_re;
    logic [AW-1:0]  mem_ra;

    logic [EW-1:0]  limit_e;
    logic [EW-1:0]  mbb_e;
    logic [EW-1:0]  fixed_e;
    logic [EW-1:0]  count_e;
    logic [2:0]     dlen;
    logic [7:0]     cand [MAX_DELIMITER_BYTES];
    logic [WFW-1:0] wfill_inc;
    logic           hit;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(BUFFER_DEPTH)) begin
            s = s - SW'(BUFFER_DEPTH);
        end
        return AW'(s);
    endfunction

    function automatic logic [7:0] delim_byte(input logic [31:0] bytes,
                                              input logic [2:0] idx);
        logic [7:0] b;
        b = '0;
        if (idx < 3'(DELIM_REG_BYTES)) begin
            b = bytes[{idx[1:0], 3'b000} +: 8];
        end
        return b;
    endfunction

    // effective limits after clamping the registers
    always_comb begin
        mbb_e   = EW'(i_cfg.max_buffer_bytes);
        count_e = EW'(r_count);
        if (mbb_e == '0) begin
            limit_e = EW'(1);
        end else if (mbb_e > EW'(BUFFER_DEPTH)) begin
            limit_e = EW'(BUFFER_DEPTH);
        end else begin
            limit_e = mbb_e;
        end
        fixed_e = (i_cfg.fixed_frame_bytes == '0) ? EW'(1) : EW'(i_cfg.fixed_frame_bytes);
        if (i_cfg.delimiter_length == '0) begin
            dlen = 3'd1;
        end else if ({1'b0, i_cfg.delimiter_length} > 4'(MAX_DELIMITER_BYTES)) begin
            dlen = 3'(MAX_DELIMITER_BYTES);
        end else begin
            dlen = i_cfg.delimiter_length;
        end
    end

    // window with the byte just read, newest first
    always_comb begin
        cand[0] = r_rdata;
        for (int j = 1; j < MAX_DELIMITER_BYTES; j++) begin
            cand[j] = r_win[j-1];
        end
        wfill_inc = (r_wfill == WFW'(MAX_DELIMITER_BYTES)) ? r_wfill : r_wfill + 1'b1;
        hit = (int'(wfill_inc) >= int'(dlen));
        for (int j = 0; j < MAX_DELIMITER_BYTES; j++) begin
            if (j < int'(dlen)) begin
                if (cand[j] != delim_byte(i_cfg.delimiter_bytes, 3'(int'(dlen) - 1 - j))) begin
                    hit = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_head     = r_head;
        n_count    = r_count;
        n_scan     = r_scan;
        n_rem      = r_rem;
        n_wfill    = r_wfill;
        n_win      = r_win;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res.frame_byte = r_rdata;
        o_res.frame_last = (r_rem == CW'(1));
        mem_we     = 1'b0;
        mem_wa     = r_head;
        mem_re     = 1'b0;
        mem_ra     = r_head;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.kind)
                        CMD_RAW: begin
                            if (!i_res_full) begin
                                o_res_push       = 1'b1;
                                o_res.frame_byte = i_cmd.data;
                                o_res.frame_last = 1'b1;
                                o_cmd_pop        = 1'b1;
                            end
                        end
                        CMD_BYTE: begin
                            o_cmd_pop = 1'b1;
                            mem_we    = 1'b1;
                            if (count_e >= limit_e) begin
                                // full buffer starts over with this item
                                mem_wa  = r_head;
                                n_count = CW'(1);
                                n_scan  = '0;
                                n_wfill = '0;
                            end else begin
                                mem_wa  = wrap_add(r_head, r_count);
                                n_count = r_count + 1'b1;
                            end
                            if (i_cfg.framing_mode == MODE_LINE) begin
                                n_state = ST_SCAN_RD;
                            end else begin
                                n_scan  = '0;
                                n_wfill = '0;
                                if (i_cfg.framing_mode == MODE_FIXED) begin
                                    n_state = ST_FIX;
                                end
                            end
                        end
                        CMD_FLUSH: begin
                            o_cmd_pop = 1'b1;
                            if (r_count != '0) begin
                                n_rem   = r_count;
                                n_after = ST_IDLE;
                                n_state = ST_EMIT_RD;
                                n_scan  = '0;
                                n_wfill = '0;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_FIX: begin
                if (count_e >= fixed_e) begin
                    n_rem   = CW'(fixed_e);
                    n_after = ST_FIX;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                if (r_scan < r_count) begin
                    mem_re  = 1'b1;
                    mem_ra  = wrap_add(r_head, r_scan);
                    n_state = ST_SCAN_CHK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_CHK: begin
                if (hit) begin
                    n_rem   = r_scan + 1'b1;
                    n_scan  = '0;
                    n_wfill = '0;
                    n_after = ST_SCAN_RD;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_win   = cand;
                    n_wfill = wfill_inc;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD: begin
                // room is reserved here, only pops happen until the write
                if (!i_res_full) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_head;
                    n_state = ST_EMIT_WR;
                end
            end
            ST_EMIT_WR: begin
                o_res_push = 1'b1;
                n_head     = wrap_add(r_head, CW'(1));
                n_count    = r_count - 1'b1;
                n_rem      = r_rem - 1'b1;
                n_state    = (r_rem == CW'(1)) ? r_after : ST_EMIT_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // new settings may change what counts as a match
        if (i_cfg_we) begin
            n_scan  = '0;
            n_wfill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_scan  <= '0;
            r_rem   <= '0;
            r_wfill <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_head  <= n_head;
            r_count <= n_count;
            r_scan  <= n_scan;
            r_rem   <= n_rem;
            r_wfill <= n_wfill;
        end
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rdata <= r_store[mem_ra];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/serial_stream_framer_top.sv =====
// ----------------------------------------------------------------------------
// serial_stream_framer_top
// cuts received serial bytes into frames in raw, fixed, line or idle-gap mode
// ----------------------------------------------------------------------------
// Items enter through a queue-style push port and are classified by the front
// stage (byte, raw byte or idle flush; ticks that close nothing are absorbed),
// then wait in a four-entry command queue for the frame sequencer. Results
// leave through a four-entry output queue, one frame byte per item, with
// frame_last on the final byte. A raw byte bypasses the frame buffer. A
// buffered byte is written into the buffer when its command is popped; in line
// mode the sequencer then checks each newly stored byte in a read state and a
// check state, resuming where the previous search stopped (a configuration
// write restarts the search from the head of the buffer). Every emitted frame
// byte passes through a read state and a write state, as the frame buffer has
// a single read port. The buffer needs no clearing pass after reset.
`default_nettype none

module serial_stream_framer_top #(
    parameter int BUFFER_DEPTH        = sfr_pkg::BUFFER_DEPTH_DEF,
    parameter int MAX_DELIMITER_BYTES = sfr_pkg::MAX_DELIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  sfr_pkg::t_in_item                 i_item,
    output logic                              empty,
    input  logic                              pop,
    output sfr_pkg::t_out_item                o_result,
    input  logic                              i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    import sfr_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_out_item);

    t_cfg             r_cfg;
    logic             cmd_push;
    t_cmd             cmd_in;
    logic             cmd_full;
    logic [CMD_W-1:0] cmd_out;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_push;
    t_out_item        res_in;
    logic             res_full;
    logic [RES_W-1:0] res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.framing_mode      <= MODE_RAW;
            r_cfg.fixed_frame_bytes <= FIXED_BYTES_RST;
            r_cfg.delimiter_bytes   <= DELIM_BYTES_RST;
            r_cfg.delimiter_length  <= DELIM_LENGTH_RST;
            r_cfg.idle_gap_ticks    <= IDLE_GAP_RST;
            r_cfg.max_buffer_bytes  <= MAX_BUFFER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAMING_MODE: r_cfg.framing_mode      <= t_mode'(i_cfg_wdata[1:0]);
                REG_FIXED_BYTES:  r_cfg.fixed_frame_bytes <= i_cfg_wdata[6:0];
                REG_DELIM_BYTES:  r_cfg.delimiter_bytes   <= i_cfg_wdata[31:0];
                REG_DELIM_LENGTH: r_cfg.delimiter_length  <= i_cfg_wdata[2:0];
                REG_IDLE_GAP:     r_cfg.idle_gap_ticks    <= i_cfg_wdata[15:0];
                REG_MAX_BUFFER:   r_cfg.max_buffer_bytes  <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    sfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    sfr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    sfr_back #(
        .BUFFER_DEPTH        (BUFFER_DEPTH),
        .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_we    (i_cfg_we),
        .i_cmd       (t_cmd'(cmd_out)),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    sfr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_result = t_out_item'(res_out);

endmodule

`default_nettype wire

// ===== hdl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker
// port-level checks on the framer output queue and reset behavior
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_stream_framer_top_defines.svh"

module sfr_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               full,
    input  logic               empty,
    input  logic               pop,
    input  sfr_pkg::t_out_item o_result
);

    // a waiting item stays put until taken
    `SFR_ASSERT_NXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_result), "result changed while waiting")

    // both queues come out of reset empty
    `SFR_ASSERT_IMP(a_reset_clean, i_clk, i_rst_n, $rose(i_rst_n), empty && !full, "queues not clear after reset")

    // nothing can reach the output in the first cycle after reset
    `SFR_ASSERT_NXT(a_min_latency, i_clk, i_rst_n, $rose(i_rst_n), empty, "result appeared too early after reset")

endmodule

bind serial_stream_framer_top sfr_checker u_sfr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

`default_nettype wire

// ===== test/sfr_frame_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_frame_checker
// tracks register writes and accepted items on the framer ports, works out the
// frame bytes each item should release, and compares every popped item in order
// ----------------------------------------------------------------------------
module sfr_frame_checker #(
    parameter int BUF_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF,
    parameter int MAX_DELIM = sfr_pkg::MAX_DELIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  sfr_pkg::t_in_item              i_item,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  sfr_pkg::t_out_item             i_result,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    import sfr_pkg::*;

    t_mode       mode_q;
    logic [6:0]  fixed_len_q;
    logic [31:0] delim_q;
    logic [2:0]  delim_len_q;
    logic [15:0] gap_q;
    logic [6:0]  buf_limit_q;

    logic [7:0]  frame_mem [BUF_DEPTH];
    int          held;
    logic [15:0] ticks_since_byte;
    t_out_item   frames_due [$];
    int          fail_cnt;
    int          checked_cnt;

    task automatic flag(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // queue one expected frame item at the tail
    task automatic expect_item(input logic [7:0] b, input logic last);
        t_out_item r;
        r.frame_byte = b;
        r.frame_last = last;
        frames_due.insert(frames_due.size(), r);
    endtask

    // release the oldest n buffered bytes as one frame
    task automatic emit_head(input int n);
        if (n == 0 || n > held) begin
            return;
        end
        for (int i = 0; i < n; i++) begin
            expect_item(frame_mem[i], i == n - 1);
        end
        for (int i = 0; i + n < held; i++) begin
            frame_mem[i] = frame_mem[i + n];
        end
        held -= n;
    endtask

    // position just past the first full delimiter, 0 when there is none
    function automatic int delimiter_end(input int len);
        bit hit;
        for (int pos = 0; pos + len <= held; pos++) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++) begin
                if (frame_mem[pos + k] != delim_q[8*k +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                return pos + len;
            end
        end
        return 0;
    endfunction

    task automatic predict_frames(input t_in_item it);
        int lim;
        int flen;
        int dlen;
        int stop;
        if (it.opcode == OP_TICK) begin
            if (ticks_since_byte != 16'hFFFF) begin
                ticks_since_byte++;
            end
            if (mode_q == MODE_IDLE && held > 0 && ticks_since_byte >= gap_q) begin
                emit_head(held);
            end
            return;
        end
        ticks_since_byte = '0;
        if (mode_q == MODE_RAW) begin
            expect_item(it.rx_byte, 1'b1);
            return;
        end
        lim = buf_limit_q;
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > BUF_DEPTH) begin
            lim = BUF_DEPTH;
        end
        // byte arriving on a full buffer drops what was held
        if (held >= lim) begin
            held = 0;
        end
        frame_mem[held] = it.rx_byte;
        held++;
        if (mode_q == MODE_FIXED) begin
            flen = (fixed_len_q == 0) ? 1 : fixed_len_q;
            while (held >= flen) begin
                emit_head(flen);
            end
        end else if (mode_q == MODE_LINE) begin
            dlen = delim_len_q;
            if (dlen < 1) begin
                dlen = 1;
            end
            if (dlen > MAX_DELIM) begin
                dlen = MAX_DELIM;
            end
            forever begin
                stop = delimiter_end(dlen);
                if (stop == 0) begin
                    break;
                end
                emit_head(stop);
            end
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        checked_cnt++;
        if (frames_due.size() == 0) begin
            flag($sformatf("unexpected frame item: byte %02h last %0b",
                           got.frame_byte, got.frame_last));
        end else begin
            want = frames_due.pop_front();
            if (got.frame_byte !== want.frame_byte || got.frame_last !== want.frame_last) begin
                flag($sformatf("frame item %0d: expected byte %02h last %0b, got byte %02h last %0b",
                               checked_cnt, want.frame_byte, want.frame_last,
                               got.frame_byte, got.frame_last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q           = MODE_RAW;
            fixed_len_q      = FIXED_BYTES_RST;
            delim_q          = DELIM_BYTES_RST;
            delim_len_q      = DELIM_LENGTH_RST;
            gap_q            = IDLE_GAP_RST;
            buf_limit_q      = MAX_BUFFER_RST;
            held             = 0;
            ticks_since_byte = '0;
            frames_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                check_result(i_result);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAMING_MODE: mode_q      = t_mode'(i_cfg_wdata[1:0]);
                    REG_FIXED_BYTES:  fixed_len_q = i_cfg_wdata[6:0];
                    REG_DELIM_BYTES:  delim_q     = i_cfg_wdata[31:0];
                    REG_DELIM_LENGTH: delim_len_q = i_cfg_wdata[2:0];
                    REG_IDLE_GAP:     gap_q       = i_cfg_wdata[15:0];
                    REG_MAX_BUFFER:   buf_limit_q = i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                predict_frames(i_item);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= frames_due.size();
        o_checked    <= checked_cnt;
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// serial stream framer testbench
// drives bytes and ticks through all four framing modes, with register
// settings swept between phases and random idling on both queue ports
// ----------------------------------------------------------------------------
module tb;
    import sfr_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_OFF      = 400;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    t_in_item              item_drv;
    logic                  empty;
    logic                  pop;
    t_out_item             result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int items_sent     = 0;

    always #5 clk = ~clk;

    serial_stream_framer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_item      (item_drv),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    sfr_frame_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item_drv),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // receiver: random stalls, plus a long hold-off counted here
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // push stays high after acceptance so back-to-back items never glitch it
    task automatic send_item(input logic op, input logic [7:0] data);
        t_in_item it;
        it.opcode  = op;
        it.rx_byte = data;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        item_drv <= it;
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    // stop offering, wait for every frame byte, then let the block go quiet
    task automatic settle();
        push <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic reg_close();
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    task automatic run_segment(input int seg);
        t_mode       m;
        logic [31:0] delim;
        logic [31:0] dlen_raw;
        int          dl;
        int          gap;
        int          n;
        int          r;
        int          burst;
        int          ticks;
        m = t_mode'(seg % 4);
        settle();
        set_idling(seg / 4);
        r     = $urandom_range(99, 0);
        delim = (r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : $urandom();
        dlen_raw = $urandom_range(0, 7);
        dl    = (dlen_raw < 1) ? 1 : (dlen_raw > MAX_DELIM_DEF) ? MAX_DELIM_DEF : dlen_raw;
        gap   = $urandom_range(0, 6);
        reg_write(REG_FRAMING_MODE, 32'(m));
        r = $urandom_range(99, 0);
        reg_write(REG_FIXED_BYTES, (r < 15) ? $urandom_range(0, 127) : $urandom_range(1, 8));
        reg_write(REG_DELIM_BYTES, delim);
        reg_write(REG_DELIM_LENGTH, dlen_raw);
        reg_write(REG_IDLE_GAP, gap);
        r = $urandom_range(99, 0);
        reg_write(REG_MAX_BUFFER, (r < 20) ? $urandom_range(0, 127) :
                                  (r < 40) ? $urandom_range(1, 8) : 64);
        reg_close();
        n = 0;
        while (n < 18) begin
            r = $urandom_range(99, 0);
            case (m)
                MODE_LINE: begin
                    if (r < 30) begin
                        for (int k = 0; k < dl; k++) begin
                            send_item(OP_BYTE, delim[8*k +: 8]);
                        end
                        n += dl;
                    end else if (r < 40) begin
                        // broken delimiter: all but its last byte
                        for (int k = 0; k + 1 < dl; k++) begin
                            send_item(OP_BYTE, delim[8*k +: 8]);
                        end
                        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                        n += dl;
                    end else begin
                        send_item(r < 45 ? OP_TICK : OP_BYTE, 8'($urandom_range(0, 255)));
                        n++;
                    end
                end
                MODE_IDLE: begin
                    burst = $urandom_range(1, 6);
                    for (int k = 0; k < burst; k++) begin
                        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                    end
                    ticks = (r < 75) ? gap + $urandom_range(0, 2) : $urandom_range(0, gap);
                    for (int k = 0; k < ticks; k++) begin
                        send_item(OP_TICK, 8'($urandom_range(0, 255)));
                    end
                    n += burst + ticks;
                end
                default: begin
                    send_item(r < 8 ? OP_TICK : OP_BYTE, 8'($urandom_range(0, 255)));
                    n++;
                end
            endcase
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        push      = 1'b0;
        item_drv  = '0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: raw mode, ticks only age the idle counter
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'hA5);
        send_item(OP_BYTE, 8'h5A);
        // receiver holds off while raw items pile up until push is refused
        hold_cycles = HOLD_OFF;
        for (int i = 0; i < 30; i++) begin
            send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        settle();

        // fixed length of zero behaves as one
        reg_write(REG_FRAMING_MODE, 32'(MODE_FIXED));
        reg_write(REG_FIXED_BYTES, 32'd0);
        reg_close();
        send_item(OP_BYTE, 8'h3C);
        settle();

        // length beyond a one-byte buffer never completes, each byte clears the last
        reg_write(REG_FIXED_BYTES, 32'd127);
        reg_write(REG_MAX_BUFFER, 32'd0);
        reg_close();
        send_item(OP_BYTE, 8'h11);
        send_item(OP_BYTE, 8'h22);
        settle();

        // held byte survives the mode change; one byte then closes two lines
        reg_write(REG_FRAMING_MODE, 32'(MODE_LINE));
        reg_write(REG_MAX_BUFFER, 32'd127);
        reg_write(REG_DELIM_BYTES, 32'h22);
        reg_write(REG_DELIM_LENGTH, 32'd0);
        reg_close();
        send_item(OP_BYTE, 8'h22);
        settle();

        // delimiter length clamps to four
        reg_write(REG_DELIM_BYTES, 32'hFFFF_FFFF);
        reg_write(REG_DELIM_LENGTH, 32'd7);
        reg_close();
        send_item(OP_BYTE, 8'h01);
        for (int i = 0; i < 4; i++) begin
            send_item(OP_BYTE, 8'hFF);
        end
        settle();
        reg_write(REG_DELIM_BYTES, 32'h0);
        reg_write(REG_DELIM_LENGTH, 32'd5);
        reg_close();
        for (int i = 0; i < 4; i++) begin
            send_item(OP_BYTE, 8'h00);
        end
        settle();

        // zero gap: first tick after a byte closes the frame, empty buffer stays silent
        reg_write(REG_FRAMING_MODE, 32'(MODE_IDLE));
        reg_write(REG_IDLE_GAP, 32'd0);
        reg_close();
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, 8'h77);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_TICK, 8'h00);
        settle();

        // ticks age a held byte outside idle mode, then idle mode closes it on the next tick
        reg_write(REG_FRAMING_MODE, 32'(MODE_FIXED));
        reg_write(REG_FIXED_BYTES, 32'd64);
        reg_write(REG_MAX_BUFFER, 32'd64);
        reg_close();
        send_item(OP_BYTE, 8'h44);
        for (int i = 0; i < 8; i++) begin
            send_item(OP_TICK, 8'($urandom_range(0, 255)));
        end
        settle();
        reg_write(REG_FRAMING_MODE, 32'(MODE_IDLE));
        reg_write(REG_IDLE_GAP, 32'd5);
        reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_HI, 32'h0000_0003);
        reg_close();
        send_item(OP_TICK, 8'h99);

        for (int seg = 0; seg < 16; seg++) begin
            run_segment(seg);
        end

        set_idling(0);
        settle();
        $display("covered %0d pushed items over raw, fixed, line and idle-gap framing", items_sent);
        $display("%0d frame bytes compared, including overflow clears and output backpressure",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("serial_stream_framer_top: match");
        end else begin
            $display("serial_stream_framer_top: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("serial_stream_framer_top: mismatch");
        $finish;
    end

endmodule
